### rtl/core/vsd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vsd_pkg
// Shared types and constants of the varint stream decoder.
// ----------------------------------------------------------------------------
package vsd_pkg;

    localparam int unsigned MAX_BYTES   = 10;
    localparam int unsigned VALUE_W     = 64;
    localparam int unsigned COUNT_W     = 4;
    localparam int unsigned SHIFT_W     = 6;
    localparam int unsigned OUT_DATA_W  = 72;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_INCOMPLETE = 2'd1,
        ST_OVERLONG   = 2'd2
    } t_status;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       buffer_end;
    } t_in_beat;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [COUNT_W-1:0] length;
        t_status            status;
    } t_result;

    // (v >> 1) ^ -(v & 1)
    function automatic logic [VALUE_W-1:0] zigzag_decode(input logic [VALUE_W-1:0] v);
        return {1'b0, v[VALUE_W-1:1]} ^ {VALUE_W{v[0]}};
    endfunction

endpackage
`default_nettype wire

### rtl/core/vsd_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vsd_in_stage
// Input register: holds one byte beat until the decode stage takes it.
// ----------------------------------------------------------------------------
module vsd_in_stage (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire vsd_pkg::t_in_beat i_beat,
    output logic                   o_ready,
    input  wire logic              i_take,
    output logic                   o_valid,
    output vsd_pkg::t_in_beat      o_beat
);
    import vsd_pkg::*;

    logic     r_valid;
    t_in_beat r_beat;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_beat  = r_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_beat <= i_beat;
        end
    end

endmodule
`default_nettype wire

### rtl/core/vsd_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vsd_core
// Accumulator and byte count with the per-byte decode and result selection.
// ----------------------------------------------------------------------------
module vsd_core (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_fire,
    input  wire vsd_pkg::t_in_beat i_beat,
    input  wire logic              i_signed_mode,
    output logic                   o_emit,
    output vsd_pkg::t_result       o_result
);
    import vsd_pkg::*;

    logic [VALUE_W-1:0] r_acc;
    logic [COUNT_W-1:0] r_count;
    logic [VALUE_W-1:0] n_acc;
    logic [COUNT_W-1:0] n_count;
    logic [SHIFT_W-1:0] shift;
    logic [COUNT_W+2:0] shift_full;
    logic [VALUE_W-1:0] finished;
    logic               is_term;
    logic               is_overlong;

    // 7 * count, count stays below MAX_BYTES so it fits in six bits
    assign shift_full = {r_count, 3'b000} - {3'b000, r_count};
    assign shift      = shift_full[SHIFT_W-1:0];

    assign n_acc       = r_acc | ({{(VALUE_W-7){1'b0}}, i_beat.data_byte[6:0]} << shift);
    assign n_count     = r_count + COUNT_W'(1);
    assign is_term     = !i_beat.data_byte[7];
    assign is_overlong = n_count >= COUNT_W'(MAX_BYTES);
    assign finished    = i_signed_mode ? zigzag_decode(n_acc) : n_acc;

    always_comb begin
        o_emit          = 1'b1;
        o_result.value  = finished;
        o_result.length = n_count;
        o_result.status = ST_OK;
        if (is_term) begin
            o_result.status = ST_OK;
        end else if (is_overlong) begin
            o_result.length = COUNT_W'(MAX_BYTES);
            o_result.status = ST_OVERLONG;
        end else if (i_beat.buffer_end) begin
            o_result.length = '0;
            o_result.status = ST_INCOMPLETE;
        end else begin
            o_emit = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_count <= '0;
        end else if (i_fire) begin
            if (o_emit) begin
                r_acc   <= '0;
                r_count <= '0;
            end else begin
                r_acc   <= n_acc;
                r_count <= n_count;
            end
        end
    end

endmodule
`default_nettype wire

### rtl/core/vsd_out_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vsd_out_stage
// Result register on the master side; frees itself when its beat is taken.
// ----------------------------------------------------------------------------
module vsd_out_stage (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_load,
    input  wire vsd_pkg::t_result i_result,
    input  wire logic             i_ready,
    output logic                  o_free,
    output logic                  o_valid,
    output vsd_pkg::t_result      o_result
);
    import vsd_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule
`default_nettype wire

### rtl/core/varint_stream_decoder_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// varint_stream_decoder_unit
// LEB128 varint decoder taking one encoded byte per beat.
// ----------------------------------------------------------------------------
// Usage:
//   slave side  : one encoded byte per beat, tlast marks the last byte of the
//                 buffer; a byte with bit 7 clear ends a value
//   master side : one result beat per finished value, tdata carries the value
//                 and byte count, tuser the status (ok, incomplete, overlong)
//   config      : i_cfg_data selects zigzag (signed) decoding; write it only
//                 while no byte is in flight; o_cfg_ready is always high
// Throughput is one byte per cycle unless the receiver stalls. Each byte needs
// one shift-and-or into the accumulator, done in the single decode stage between
// the input register and the result register.
// A byte accepted at the slave side is held in the input register; its result
// is then loaded into the result register, which drives the master side.
// When the receiver stalls, the result register holds its beat; the input
// register still takes one byte, and further bytes are refused only if that
// byte would produce a result while the result register is still full.
// Reset clears the accumulator, the byte count, both registers' valid flags
// and selects unsigned mode.
// ----------------------------------------------------------------------------
module varint_stream_decoder_unit (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // slave side
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [7:0]   s_axis_tdata,   // [7:0] data_byte
    input  wire logic         s_axis_tlast,   // buffer_end
    // master side
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [vsd_pkg::OUT_DATA_W-1:0] m_axis_tdata, // [63:0] value, [67:64] length, rest 0
    output logic [1:0]        m_axis_tuser,   // [1:0] status
    // configuration
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic         i_cfg_data      // [0] signed_mode
);
    import vsd_pkg::*;

    logic     r_signed_mode;
    t_in_beat s_beat;
    t_in_beat held_beat;
    logic     held_valid;
    logic     fire;
    logic     emit;
    logic     out_free;
    t_result  core_result;
    t_result  out_result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_signed_mode <= 1'b0;
        end else if (i_cfg_valid) begin
            r_signed_mode <= i_cfg_data;
        end
    end

    assign s_beat.data_byte  = s_axis_tdata;
    assign s_beat.buffer_end = s_axis_tlast;

    // a continuing byte never needs the result register
    assign fire = held_valid && (out_free || !emit);

    vsd_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_beat  (s_beat),
        .o_ready (s_axis_tready),
        .i_take  (fire),
        .o_valid (held_valid),
        .o_beat  (held_beat)
    );

    vsd_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (fire),
        .i_beat        (held_beat),
        .i_signed_mode (r_signed_mode),
        .o_emit        (emit),
        .o_result      (core_result)
    );

    vsd_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (fire && emit),
        .i_result (core_result),
        .i_ready  (m_axis_tready),
        .o_free   (out_free),
        .o_valid  (m_axis_tvalid),
        .o_result (out_result)
    );

    assign m_axis_tdata = {{(OUT_DATA_W-VALUE_W-COUNT_W){1'b0}},
                           out_result.length, out_result.value};
    assign m_axis_tuser = out_result.status;

    // assertions
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser != 2'd3))
        else $error("result status code out of range");

    a_ok_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == ST_OK) |->
        (out_result.length != '0 && out_result.length <= COUNT_W'(MAX_BYTES)))
        else $error("ok result with bad byte count");

    a_incomplete_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == ST_INCOMPLETE) |-> (out_result.length == '0))
        else $error("incomplete result with nonzero byte count");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (held_valid && emit && m_axis_tvalid && !m_axis_tready))
        else $error("input refused without a pending result");

endmodule
`default_nettype wire
